FILE: hw/rtl/mpl_pkg.sv
package mpl_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int MAX_DIM    = 1024;
    localparam int MAX_KERNEL = 8;
    localparam int DIM_W      = 11;
    localparam int POS_W      = 10;
    localparam int IDX_W      = 11;
    localparam int SUM_W      = 12;
    localparam int KER_W      = 4;
    localparam int SLOT_W     = 3;
    localparam int ADDR_W     = SLOT_W + POS_W;
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 32;

    // register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_IN_HEIGHT  = 3'd0,
        REG_IN_WIDTH   = 3'd1,
        REG_KERNEL_H   = 3'd2,
        REG_KERNEL_W   = 3'd3,
        REG_STRIDE_H   = 3'd4,
        REG_STRIDE_W   = 3'd5,
        REG_OUT_HEIGHT = 3'd6,
        REG_OUT_WIDTH  = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_in_tensor;
    } pix_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] pooled_max;
        logic [POS_W-1:0]           out_row;
        logic [POS_W-1:0]           out_col;
        logic                       last_of_run;
        logic                       plane_done;
        logic                       tensor_done;
    } pool_t;

    // clamped working configuration
    typedef struct packed {
        logic [DIM_W-1:0] ih;
        logic [DIM_W-1:0] iw;
        logic [KER_W-1:0] kh;
        logic [KER_W-1:0] kw;
        logic [KER_W-1:0] sh;
        logic [KER_W-1:0] sw;
        logic [POS_W-1:0] ohm1;
        logic [POS_W-1:0] owm1;
        logic             restart;
    } cfg_t;

    typedef struct packed {
        logic start;
        logic rd;
        logic wr;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic loop_last;
        logic emit_hit;
        logic pend_valid;
        logic out_free;
    } stat_t;

endpackage

FILE: hw/rtl/mpl_cfg.sv
module mpl_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mpl_pkg::PADDR_W-1:0]     paddr,
    input  logic [mpl_pkg::PDATA_W-1:0]     pwdata,
    output logic [mpl_pkg::PDATA_W-1:0]     prdata,
    output mpl_pkg::cfg_t                   cfg
);
    import mpl_pkg::*;

    logic [DIM_W-1:0] in_height_reg, in_width_reg, out_height_reg, out_width_reg;
    logic [KER_W-1:0] kernel_h_reg, kernel_w_reg, stride_h_reg, stride_w_reg;
    logic             wr_en;
    reg_idx_t         idx;
    logic [DIM_W-1:0] ohc, owc;

    assign wr_en = psel && penable && pwrite;
    assign idx   = reg_idx_t'(paddr[PADDR_W-1:2]);

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_height_reg  <= DIM_W'(1);
            in_width_reg   <= DIM_W'(1);
            kernel_h_reg   <= KER_W'(2);
            kernel_w_reg   <= KER_W'(2);
            stride_h_reg   <= KER_W'(2);
            stride_w_reg   <= KER_W'(2);
            out_height_reg <= DIM_W'(1);
            out_width_reg  <= DIM_W'(1);
        end
        else if (wr_en)
        begin
            case (idx)
                REG_IN_HEIGHT:  in_height_reg  <= pwdata[DIM_W-1:0];
                REG_IN_WIDTH:   in_width_reg   <= pwdata[DIM_W-1:0];
                REG_KERNEL_H:   kernel_h_reg   <= pwdata[KER_W-1:0];
                REG_KERNEL_W:   kernel_w_reg   <= pwdata[KER_W-1:0];
                REG_STRIDE_H:   stride_h_reg   <= pwdata[KER_W-1:0];
                REG_STRIDE_W:   stride_w_reg   <= pwdata[KER_W-1:0];
                REG_OUT_HEIGHT: out_height_reg <= pwdata[DIM_W-1:0];
                REG_OUT_WIDTH:  out_width_reg  <= pwdata[DIM_W-1:0];
                default:        in_height_reg  <= in_height_reg;
            endcase
        end
    end

    // read back
    always_comb
    begin
        prdata = '0;
        case (idx)
            REG_IN_HEIGHT:  prdata = PDATA_W'(in_height_reg);
            REG_IN_WIDTH:   prdata = PDATA_W'(in_width_reg);
            REG_KERNEL_H:   prdata = PDATA_W'(kernel_h_reg);
            REG_KERNEL_W:   prdata = PDATA_W'(kernel_w_reg);
            REG_STRIDE_H:   prdata = PDATA_W'(stride_h_reg);
            REG_STRIDE_W:   prdata = PDATA_W'(stride_w_reg);
            REG_OUT_HEIGHT: prdata = PDATA_W'(out_height_reg);
            REG_OUT_WIDTH:  prdata = PDATA_W'(out_width_reg);
            default:        prdata = '0;
        endcase
    end

    // clamp to legal working values
    always_comb
    begin
        cfg.ih = (in_height_reg == '0) ? DIM_W'(1) :
                 (in_height_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : in_height_reg;
        cfg.iw = (in_width_reg == '0) ? DIM_W'(1) :
                 (in_width_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : in_width_reg;
        cfg.kh = (kernel_h_reg == '0) ? KER_W'(1) :
                 (kernel_h_reg > KER_W'(MAX_KERNEL)) ? KER_W'(MAX_KERNEL) : kernel_h_reg;
        cfg.kw = (kernel_w_reg == '0) ? KER_W'(1) :
                 (kernel_w_reg > KER_W'(MAX_KERNEL)) ? KER_W'(MAX_KERNEL) : kernel_w_reg;
        cfg.sh = (stride_h_reg == '0) ? KER_W'(1) : stride_h_reg;
        cfg.sw = (stride_w_reg == '0) ? KER_W'(1) : stride_w_reg;
        ohc = (out_height_reg == '0) ? DIM_W'(1) :
              (out_height_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : out_height_reg;
        owc = (out_width_reg == '0) ? DIM_W'(1) :
              (out_width_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : out_width_reg;
        cfg.ohm1    = POS_W'(ohc - DIM_W'(1));
        cfg.owm1    = POS_W'(owc - DIM_W'(1));
        cfg.restart = wr_en;
    end

endmodule

FILE: hw/rtl/mpl_dp.sv
module mpl_dp (
    input  logic           clk,
    input  logic           rst_n,
    input  mpl_pkg::cfg_t  cfg,
    input  mpl_pkg::cmd_t  cmd,
    output mpl_pkg::stat_t st,
    input  mpl_pkg::pix_t  pix,
    output logic           pool_valid,
    input  logic           pool_ready,
    output mpl_pkg::pool_t pool
);
    import mpl_pkg::*;

    // position trackers for the next sample
    logic [POS_W-1:0] r_reg, c_reg;
    logic [IDX_W-1:0] hlo_reg, hhi_reg, wlo_reg, whi_reg;
    logic [SUM_W-1:0] hlo_start_reg, hhi_start_reg, wlo_start_reg, whi_start_reg;

    // captured sample and window loop
    logic [POS_W-1:0]           r_cap_reg, c_cap_reg;
    logic [IDX_W-1:0]           hend_reg, wend_reg, wlo_cap_reg;
    logic [SUM_W-1:0]           wlo_start_cap_reg;
    logic [IDX_W-1:0]           h_reg, w_reg;
    logic [SUM_W-1:0]           hs_reg, ws_reg;
    logic signed [SAMPLE_W-1:0] samp_reg;
    logic                       lastt_reg;

    // partial maximum store
    logic signed [SAMPLE_W-1:0] mem [2**ADDR_W];
    logic signed [SAMPLE_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]          addr;

    // pending and output results
    logic  pend_valid_reg, pool_valid_reg;
    pool_t pend_reg, pool_reg;

    logic [IDX_W-1:0]           hend, wend;
    logic [SUM_W-1:0]           r_ext, c_ext, ih_ext, iw_ext;
    logic [SUM_W-1:0]           hsk, wsk, rend, cend;
    logic                       seed, row_hit, col_hit, pd;
    logic signed [SAMPLE_W-1:0] new_max;
    logic                       out_free, col_wrap, row_wrap;
    pool_t                      cur;
    pool_t                      flush_res;

    assign r_ext  = SUM_W'(r_reg);
    assign c_ext  = SUM_W'(c_reg);
    assign ih_ext = SUM_W'(cfg.ih);
    assign iw_ext = SUM_W'(cfg.iw);
    assign hend   = (hhi_reg > IDX_W'(cfg.ohm1)) ? IDX_W'(cfg.ohm1) : hhi_reg;
    assign wend   = (whi_reg > IDX_W'(cfg.owm1)) ? IDX_W'(cfg.owm1) : whi_reg;
    assign col_wrap = (SUM_W'(c_reg) + SUM_W'(1)) >= iw_ext;
    assign row_wrap = (SUM_W'(r_reg) + SUM_W'(1)) >= ih_ext;

    // position tracking, advanced as each sample is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg <= '0; c_reg <= '0;
            hlo_reg <= '0; hhi_reg <= '0; wlo_reg <= '0; whi_reg <= '0;
            hlo_start_reg <= '0; hhi_start_reg <= '0;
            wlo_start_reg <= '0; whi_start_reg <= '0;
        end
        else if (cfg.restart || (cmd.start && col_wrap && row_wrap))
        begin
            r_reg <= '0; c_reg <= '0;
            hlo_reg <= '0; hhi_reg <= '0; wlo_reg <= '0; whi_reg <= '0;
            hlo_start_reg <= '0; hhi_start_reg <= '0;
            wlo_start_reg <= '0; whi_start_reg <= '0;
        end
        else if (cmd.start && col_wrap)
        begin
            c_reg <= '0;
            wlo_reg <= '0; whi_reg <= '0;
            wlo_start_reg <= '0; whi_start_reg <= '0;
            r_reg <= r_reg + POS_W'(1);
            if (r_ext == hlo_start_reg + SUM_W'(cfg.kh) - SUM_W'(1))
            begin
                hlo_reg       <= hlo_reg + IDX_W'(1);
                hlo_start_reg <= hlo_start_reg + SUM_W'(cfg.sh);
            end
            if (r_ext + SUM_W'(1) == hhi_start_reg + SUM_W'(cfg.sh))
            begin
                hhi_reg       <= hhi_reg + IDX_W'(1);
                hhi_start_reg <= hhi_start_reg + SUM_W'(cfg.sh);
            end
        end
        else if (cmd.start)
        begin
            c_reg <= c_reg + POS_W'(1);
            if (c_ext == wlo_start_reg + SUM_W'(cfg.kw) - SUM_W'(1))
            begin
                wlo_reg       <= wlo_reg + IDX_W'(1);
                wlo_start_reg <= wlo_start_reg + SUM_W'(cfg.sw);
            end
            if (c_ext + SUM_W'(1) == whi_start_reg + SUM_W'(cfg.sw))
            begin
                whi_reg       <= whi_reg + IDX_W'(1);
                whi_start_reg <= whi_start_reg + SUM_W'(cfg.sw);
            end
        end
    end

    // sample capture and window loop counters
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            r_cap_reg         <= r_reg;
            c_cap_reg         <= c_reg;
            hend_reg          <= hend;
            wend_reg          <= wend;
            wlo_cap_reg       <= wlo_reg;
            wlo_start_cap_reg <= wlo_start_reg;
            h_reg             <= hlo_reg;
            hs_reg            <= hlo_start_reg;
            w_reg             <= wlo_reg;
            ws_reg            <= wlo_start_reg;
            samp_reg          <= pix.sample;
            lastt_reg         <= pix.last_in_tensor;
        end
        else if (cmd.wr)
        begin
            if (w_reg == wend_reg)
            begin
                h_reg  <= h_reg + IDX_W'(1);
                hs_reg <= hs_reg + SUM_W'(cfg.sh);
                w_reg  <= wlo_cap_reg;
                ws_reg <= wlo_start_cap_reg;
            end
            else
            begin
                w_reg  <= w_reg + IDX_W'(1);
                ws_reg <= ws_reg + SUM_W'(cfg.sw);
            end
        end
    end

    // store access, read registered ahead of the update
    assign addr = {h_reg[SLOT_W-1:0], w_reg[POS_W-1:0]};

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            rd_data_reg <= mem[addr];
        end
        if (cmd.wr)
        begin
            mem[addr] <= new_max;
        end
    end

    // window update and close test
    always_comb
    begin
        hsk  = hs_reg + SUM_W'(cfg.kh);
        wsk  = ws_reg + SUM_W'(cfg.kw);
        rend = ((hsk < ih_ext) ? hsk : ih_ext) - SUM_W'(1);
        cend = ((wsk < iw_ext) ? wsk : iw_ext) - SUM_W'(1);
        seed = (SUM_W'(r_cap_reg) == hs_reg) && (SUM_W'(c_cap_reg) == ws_reg);
        new_max = (seed || (samp_reg > rd_data_reg)) ? samp_reg : rd_data_reg;
        row_hit = (rend == SUM_W'(r_cap_reg));
        col_hit = (cend == SUM_W'(c_cap_reg));
        pd = ((h_reg == IDX_W'(cfg.ohm1)) || (hs_reg + SUM_W'(cfg.sh) >= ih_ext)) &&
             ((w_reg == IDX_W'(cfg.owm1)) || (ws_reg + SUM_W'(cfg.sw) >= iw_ext));
        cur.pooled_max  = new_max;
        cur.out_row     = h_reg[POS_W-1:0];
        cur.out_col     = w_reg[POS_W-1:0];
        cur.last_of_run = 1'b0;
        cur.plane_done  = pd;
        cur.tensor_done = pd && lastt_reg;
    end

    // pending result marked as the end of its run
    always_comb
    begin
        flush_res             = pend_reg;
        flush_res.last_of_run = 1'b1;
    end

    assign out_free = !pool_valid_reg || pool_ready;

    // pending result waits until it is known whether it ends the run
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            pool_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wr && row_hit && col_hit)
            begin
                pend_valid_reg <= 1'b1;
                pool_valid_reg <= pend_valid_reg || (pool_valid_reg && !pool_ready);
            end
            else if (cmd.flush)
            begin
                pend_valid_reg <= 1'b0;
                pool_valid_reg <= 1'b1;
            end
            else if (pool_ready)
            begin
                pool_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr && row_hit && col_hit)
        begin
            pend_reg <= cur;
            if (pend_valid_reg)
            begin
                pool_reg <= pend_reg;
            end
        end
        else if (cmd.flush)
        begin
            pool_reg <= flush_res;
        end
    end

    assign pool_valid    = pool_valid_reg;
    assign pool          = pool_reg;
    assign st.empty      = (hlo_reg > hend) || (wlo_reg > wend);
    assign st.loop_last  = (h_reg == hend_reg) && (w_reg == wend_reg);
    assign st.emit_hit   = row_hit && col_hit;
    assign st.pend_valid = pend_valid_reg;
    assign st.out_free   = out_free;

`ifndef SYNTH
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |=> pool_valid_reg && pool_reg.last_of_run)
        else $error("flushed result lacks run end mark");
    a_td_needs_pd: assert property (@(posedge clk) disable iff (!rst_n)
        pool_valid_reg |-> (!pool_reg.tensor_done || pool_reg.plane_done))
        else $error("tensor end without plane end");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr && row_hit && col_hit && pend_valid_reg |-> out_free)
        else $error("output overwritten");
`endif

endmodule

FILE: hw/rtl/mpl_ctrl.sv
module mpl_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pix_valid,
    output logic           pix_ready,
    input  mpl_pkg::stat_t st,
    output mpl_pkg::cmd_t  cmd
);
    import mpl_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_WR,
        S_FLUSH
    } state_t;

    state_t state_reg, state_next;

    // commands to the datapath
    always_comb
    begin
        cmd.start = (state_reg == S_IDLE) && pix_valid;
        cmd.rd    = (state_reg == S_RD);
        cmd.wr    = (state_reg == S_WR) && !(st.emit_hit && st.pend_valid && !st.out_free);
        cmd.flush = (state_reg == S_FLUSH) && st.pend_valid && st.out_free;
    end

    assign pix_ready = (state_reg == S_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (pix_valid)
                begin
                    state_next = st.empty ? S_FLUSH : S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_WR;
            end
            S_WR:
            begin
                if (cmd.wr)
                begin
                    state_next = st.loop_last ? S_FLUSH : S_RD;
                end
            end
            S_FLUSH:
            begin
                if (!st.pend_valid || st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTH
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !st.pend_valid)
        else $error("pending result left at idle");
    a_start_rd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start && !st.empty |=> (state_reg == S_RD))
        else $error("window loop not started");
    a_rd_wr: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd |=> (state_reg == S_WR))
        else $error("read not followed by update");
`endif

endmodule

FILE: hw/rtl/max_pool_2d_stream.sv
// Streaming 2-d max pooling: samples enter one per transaction, channel plane by
// plane, row-major; each result is one window's maximum with its output row and
// column. Every open window that a sample touches costs a read and a write on
// the single-port 8192 x 16 partial-maximum memory. The next sample is taken
// only after the current one's window loop ends; results sit in an output
// register so the loop runs ahead of a stalled consumer by one result. Any
// register write restarts the plane position at row 0, column 0.
module max_pool_2d_stream (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mpl_pkg::PADDR_W-1:0] paddr,
    input  logic [mpl_pkg::PDATA_W-1:0] pwdata,
    output logic [mpl_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        pix_valid,
    output logic                        pix_ready,
    input  mpl_pkg::pix_t               pix,
    output logic                        pool_valid,
    input  logic                        pool_ready,
    output mpl_pkg::pool_t              pool
);
    import mpl_pkg::*;

    cfg_t  cfg;
    cmd_t  cmd;
    stat_t st;

    assign pready = 1'b1;

    mpl_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    mpl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .st        (st),
        .cmd       (cmd)
    );

    mpl_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cmd        (cmd),
        .st         (st),
        .pix        (pix),
        .pool_valid (pool_valid),
        .pool_ready (pool_ready),
        .pool       (pool)
    );

endmodule

FILE: bench/max_pool_2d_stream_chk.sv
`timescale 1ns / 100ps

module max_pool_2d_stream_chk
    import mpl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    input  logic                 pready,
    input  logic                 pix_valid,
    input  logic                 pix_ready,
    input  pix_t                 pix,
    input  logic                 pool_valid,
    input  logic                 pool_ready,
    input  pool_t                pool,
    output int                   errors,
    output int                   pending
);

    // programmed register values
    logic [DIM_W-1:0] r_ih, r_iw, r_oh, r_ow;
    logic [KER_W-1:0] r_kh, r_kw, r_sh, r_sw;
    int unsigned      row_at, col_at;
    logic signed [SAMPLE_W-1:0] win_max [0:MAX_KERNEL*MAX_DIM-1];
    pool_t            pool_q [$];

    assign pending = pool_q.size();

    function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    // update open windows for one sample and queue closing windows
    task automatic pool_sample(input pix_t p);
        int unsigned ih, iw, kh, kw, sh, sw, oh, ow, r, c;
        int unsigned hlo, hhi, wlo, whi, hs, ws, rend, cend, idx, n;
        pool_t o;
        ih = clampu(r_ih, 1, MAX_DIM);
        iw = clampu(r_iw, 1, MAX_DIM);
        kh = clampu(r_kh, 1, MAX_KERNEL);
        kw = clampu(r_kw, 1, MAX_KERNEL);
        sh = (r_sh == 0) ? 1 : r_sh;
        sw = (r_sw == 0) ? 1 : r_sw;
        oh = clampu(r_oh, 1, MAX_DIM);
        ow = clampu(r_ow, 1, MAX_DIM);
        n = 0;
        if (oh > (ih - 1) / sh + 1) oh = (ih - 1) / sh + 1;
        if (ow > (iw - 1) / sw + 1) ow = (iw - 1) / sw + 1;
        if (row_at >= ih) row_at = 0;
        if (col_at >= iw) col_at = 0;
        r = row_at;
        c = col_at;
        hlo = (r + 1 > kh) ? (r + 1 - kh + sh - 1) / sh : 0;
        hhi = r / sh;
        if (hhi > oh - 1) hhi = oh - 1;
        wlo = (c + 1 > kw) ? (c + 1 - kw + sw - 1) / sw : 0;
        whi = c / sw;
        if (whi > ow - 1) whi = ow - 1;
        for (int unsigned h = hlo; h <= hhi; h++) begin
            hs = h * sh;
            rend = ((hs + kh < ih) ? hs + kh : ih) - 1;
            for (int unsigned w = wlo; w <= whi; w++) begin
                ws = w * sw;
                cend = ((ws + kw < iw) ? ws + kw : iw) - 1;
                idx = (h % MAX_KERNEL) * MAX_DIM + w;
                if (r == hs && c == ws)
                    win_max[idx] = p.sample;
                else if (p.sample > win_max[idx])
                    win_max[idx] = p.sample;
                if (r == rend && c == cend && n < 64) begin
                    o.pooled_max  = win_max[idx];
                    o.out_row     = h[POS_W-1:0];
                    o.out_col     = w[POS_W-1:0];
                    o.last_of_run = 1'b0;
                    o.plane_done  = (h == oh - 1) && (w == ow - 1);
                    o.tensor_done = o.plane_done && p.last_in_tensor;
                    pool_q.push_back(o);
                    n++;
                end
            end
        end
        if (n > 0)
            pool_q[pool_q.size()-1].last_of_run = 1'b1;
        col_at = c + 1;
        if (col_at >= iw) begin
            col_at = 0;
            row_at = r + 1;
            if (row_at >= ih) row_at = 0;
        end
    endtask

    // watch register writes, samples and results
    always @(posedge clk or negedge rst_n)
    begin
        pool_t exp_r;
        if (!rst_n)
        begin
            r_ih = DIM_W'(1); r_iw = DIM_W'(1); r_oh = DIM_W'(1); r_ow = DIM_W'(1);
            r_kh = KER_W'(2); r_kw = KER_W'(2); r_sh = KER_W'(2); r_sw = KER_W'(2);
            row_at = 0;
            col_at = 0;
            errors <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[4:2]))
                    REG_IN_HEIGHT:  r_ih = pwdata[DIM_W-1:0];
                    REG_IN_WIDTH:   r_iw = pwdata[DIM_W-1:0];
                    REG_KERNEL_H:   r_kh = pwdata[KER_W-1:0];
                    REG_KERNEL_W:   r_kw = pwdata[KER_W-1:0];
                    REG_STRIDE_H:   r_sh = pwdata[KER_W-1:0];
                    REG_STRIDE_W:   r_sw = pwdata[KER_W-1:0];
                    REG_OUT_HEIGHT: r_oh = pwdata[DIM_W-1:0];
                    REG_OUT_WIDTH:  r_ow = pwdata[DIM_W-1:0];
                    default: ;
                endcase
                row_at = 0;
                col_at = 0;
            end
            if (pool_valid && pool_ready)
            begin
                if (pool_q.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, pool);
                    errors <= errors + 1;
                end
                else
                begin
                    exp_r = pool_q.pop_front();
                    if (exp_r !== pool)
                    begin
                        $display("%0t: mismatch expected max=%0d row=%0d col=%0d flags=%b%b%b",
                                 $time, exp_r.pooled_max, exp_r.out_row, exp_r.out_col,
                                 exp_r.last_of_run, exp_r.plane_done, exp_r.tensor_done);
                        $display("%0t:          actual   max=%0d row=%0d col=%0d flags=%b%b%b",
                                 $time, pool.pooled_max, pool.out_row, pool.out_col,
                                 pool.last_of_run, pool.plane_done, pool.tensor_done);
                        errors <= errors + 1;
                    end
                end
            end
            if (pix_valid && pix_ready)
                pool_sample(pix);
        end
    end

endmodule

FILE: bench/max_pool_2d_stream_tb.sv
`timescale 1ns / 100ps

module max_pool_2d_stream_tb;
    import mpl_pkg::*;

    localparam int WATCHDOG = 20000;

    logic                clk;
    logic                rst_n;
    logic                psel, penable, pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata, prdata;
    logic                pready;
    logic                pix_valid, pix_ready;
    pix_t                pix;
    logic                pool_valid, pool_ready;
    pool_t               pool;
    int                  errors, pending;
    int                  idle_cycles;
    bit                  busy_run;

    max_pool_2d_stream u_dut (.*);

    max_pool_2d_stream_chk u_chk (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // receiver stalls at random except during a busy stretch
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pool_ready <= 1'b0;
        else
            pool_ready <= busy_run || ($urandom_range(99) >= 34);
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((pix_valid && pix_ready) || (pool_valid && pool_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // one write: setup cycle then access cycle, select left high for the next
    task automatic reg_write(input reg_idx_t idx, input int unsigned val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
    endtask

    task automatic drain_results();
        pix_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic set_shape(input int unsigned ih, iw, kh, kw, sh, sw, oh, ow);
        drain_results();
        reg_write(REG_IN_HEIGHT, ih);
        reg_write(REG_IN_WIDTH, iw);
        reg_write(REG_KERNEL_H, kh);
        reg_write(REG_KERNEL_W, kw);
        reg_write(REG_STRIDE_H, sh);
        reg_write(REG_STRIDE_W, sw);
        reg_write(REG_OUT_HEIGHT, oh);
        reg_write(REG_OUT_WIDTH, ow);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // valid stays high after a transaction unless the sender idles
    task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic lt);
        if (!busy_run && $urandom_range(99) < 34)
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
            while (!busy_run && $urandom_range(99) < 34)
                @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix       <= '{sample: s, last_in_tensor: lt};
        @(posedge clk);
        while (!pix_ready)
            @(posedge clk);
    endtask

    // send whole planes with random content
    task automatic send_planes(input int unsigned cnt, input int unsigned planes);
        int unsigned k;
        for (int unsigned p = 0; p < planes; p++)
            for (k = 0; k < cnt; k++)
                send_sample(SAMPLE_W'($urandom), (p == planes - 1) && (k == cnt - 1));
    endtask

    initial
    begin
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        pix_valid  = 1'b0;
        pix        = '0;
        busy_run   = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset shape: single sample plane
        send_sample(16'h7fff, 1'b1);
        send_sample(16'h8000, 1'b0);
        // directed extremes: 3x3 plane, 2x2 kernel, stride 1
        set_shape(3, 3, 2, 2, 1, 1, 2, 2);
        send_sample(16'h8000, 1'b0); send_sample(16'h7fff, 1'b0); send_sample(16'h0000, 1'b0);
        send_sample(16'hffff, 1'b0); send_sample(16'h8001, 1'b0); send_sample(16'h0001, 1'b0);
        send_sample(16'h8000, 1'b0); send_sample(16'h8000, 1'b0); send_sample(16'h8000, 1'b1);
        // stride above kernel, oversize outputs, zero stride and kernel clamps
        set_shape(4, 5, 1, 1, 3, 3, 1023, 1023);
        send_planes(20, 1);
        set_shape(3, 3, 0, 15, 0, 0, 0, 2047);
        send_planes(9, 1);
        // early final window with stray last flag
        set_shape(5, 5, 2, 2, 2, 2, 1, 1);
        send_sample(16'h1234, 1'b1); send_planes(24, 1);

        // random shapes, pause to drain at each change
        for (int i = 0; i < 10; i++)
        begin
            int unsigned ih, iw;
            ih = $urandom_range(1, 5);
            iw = $urandom_range(1, 6);
            set_shape(ih, iw, $urandom_range(1, 8), $urandom_range(1, 8),
                      $urandom_range(1, 8), $urandom_range(1, 8),
                      $urandom_range(1, 4), $urandom_range(1, 4));
            busy_run = (i == 5);
            send_planes(ih * iw, $urandom_range(1, 2));
            // noise: lone samples with random flag
            send_sample(SAMPLE_W'($urandom), 1'($urandom_range(1)));
        end
        busy_run = 1'b0;
        // wide row and tall column planes, large kernel, only the first samples sent
        set_shape(1, 1024, 8, 8, 8, 1, 1024, 1024);
        send_planes(40, 1);
        set_shape(1024, 1, 8, 8, 1, 8, 1024, 1024);
        send_planes(16, 1);

        drain_results();
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/mpl_pkg.sv
hw/rtl/mpl_cfg.sv
hw/rtl/mpl_dp.sv
hw/rtl/mpl_ctrl.sv
hw/rtl/max_pool_2d_stream.sv
bench/max_pool_2d_stream_chk.sv
bench/max_pool_2d_stream_tb.sv
